// File: design/hxi_pkg.sv
package hxi_pkg;

  // fixed field widths
  localparam int COORD_W = 16;
  localparam int INDEX_W = 32;
  localparam int ORDER_W = 5;

  // reset value of the order register
  localparam logic [ORDER_W-1:0] ORDER_RESET = 5'd6;

  // word handed from cell to cell
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [INDEX_W-1:0] idx;
  } hxi_word_t;

endpackage

// File: design/hxi_cell.sv
// One curve level: take the coordinate bits at LEVEL, append two index
// bits, then mirror/swap the lower coordinate bits for the next level.
module hxi_cell #(
  parameter int LEVEL = 0
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [hxi_pkg::ORDER_W-1:0]  order_eff,
  input  logic                         valid_in,
  input  hxi_pkg::hxi_word_t           word_in,
  output logic                         valid_out,
  output hxi_pkg::hxi_word_t           word_out
);

  localparam logic [hxi_pkg::COORD_W-1:0] LOW_MASK =
    hxi_pkg::COORD_W'((32'd1 << LEVEL) - 32'd1);

  logic               valid_r;
  hxi_pkg::hxi_word_t word_r;
  hxi_pkg::hxi_word_t word_nxt;
  logic               active;
  logic               rx;
  logic               ry;
  logic [hxi_pkg::COORD_W-1:0] xm;
  logic [hxi_pkg::COORD_W-1:0] ym;

  // level is processed only when it lies below the order in use
  assign active = (order_eff > hxi_pkg::ORDER_W'(LEVEL));
  assign rx     = word_in.x[LEVEL];
  assign ry     = word_in.y[LEVEL];

  // mirror against side-1: only bits below this level matter downstream
  assign xm = rx ? (word_in.x ^ LOW_MASK) : word_in.x;
  assign ym = rx ? (word_in.y ^ LOW_MASK) : word_in.y;

  always_comb begin
    word_nxt = word_in;
    if (active) begin
      word_nxt.idx = {word_in.idx[hxi_pkg::INDEX_W-3:0], rx, rx ^ ry};
      if (!ry) begin
        word_nxt.x = ym;
        word_nxt.y = xm;
      end
    end
  end

  // control register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_in;
    end
  end

  // payload register
  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign valid_out = valid_r;
  assign word_out  = word_r;

endmodule

// File: design/hilbert_xy_to_index.sv
// Hilbert curve (x, y) to curve distance. A word is accepted on every cycle
// with start high (busy is always low), and its curve_index appears on
// out_curve_index with out_valid high for one cycle once it has passed
// through every cell; the result cannot be held off, so capture it on the
// strobe. The row holds MAX_ORDER cells, one registered cell per bit
// level, each passing its word to the next every cycle. grid_order (reset 6,
// values above MAX_ORDER act as MAX_ORDER) may be written through the cfg
// channel, which is always ready; write it only while no word is in flight.
module hilbert_xy_to_index #(
  parameter int MAX_ORDER = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // configuration
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [hxi_pkg::ORDER_W-1:0]  cfg_grid_order,
  // input words
  input  logic                         start,
  output logic                         busy,
  input  logic [hxi_pkg::COORD_W-1:0]  in_x_coord,
  input  logic [hxi_pkg::COORD_W-1:0]  in_y_coord,
  // result words
  output logic                         out_valid,
  output logic [hxi_pkg::INDEX_W-1:0]  out_curve_index
);

  logic [hxi_pkg::ORDER_W-1:0] grid_order_r;
  logic [hxi_pkg::ORDER_W-1:0] order_eff;
  logic                        valid_chain [MAX_ORDER+1];
  hxi_pkg::hxi_word_t          word_chain  [MAX_ORDER+1];

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  // order register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_order_r <= hxi_pkg::ORDER_RESET;
    end else if (cfg_valid && cfg_ready) begin
      grid_order_r <= cfg_grid_order;
    end
  end

  // saturate to the number of cells
  assign order_eff = (grid_order_r > hxi_pkg::ORDER_W'(MAX_ORDER)) ?
                     hxi_pkg::ORDER_W'(MAX_ORDER) : grid_order_r;

  // feed of the first cell
  assign valid_chain[0]      = start && !busy;
  assign word_chain[0].x     = in_x_coord;
  assign word_chain[0].y     = in_y_coord;
  assign word_chain[0].idx   = '0;

  // row of cells, top level first
  for (genvar k = 0; k < MAX_ORDER; k++) begin : g_cell
    hxi_cell #(
      .LEVEL (MAX_ORDER - 1 - k)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .order_eff (order_eff),
      .valid_in  (valid_chain[k]),
      .word_in   (word_chain[k]),
      .valid_out (valid_chain[k+1]),
      .word_out  (word_chain[k+1])
    );
  end

  assign out_valid       = valid_chain[MAX_ORDER];
  assign out_curve_index = word_chain[MAX_ORDER].idx;

  // every accepted word yields its result after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##MAX_ORDER out_valid)
    else $error("result missing after accepted word");

  // no result without a matching accepted word
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, MAX_ORDER))
    else $error("result without accepted word");

  // only the low 2*order bits of the index can be set
  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_curve_index >> (2 * order_eff)) == '0))
    else $error("curve index exceeds grid size");

endmodule
